[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSR_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define PSR_ASSERT_NEVER(label, cond, msg) `PSR_ASSERT_CLK(label, !(cond), msg)
`else
`define PSR_ASSERT_CLK(label, prop, msg)
`define PSR_ASSERT_NEVER(label, cond, msg)
`endif
`endif

[hdl/psr_pkg.sv]
// ----------------------------------------------------------------------------
// Point/segment relation package
// Item types, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package psr_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int COORD_W     = 32;
   localparam int LEN_W       = 33;
   localparam int AREA_W      = 50;
   localparam int DIST_RAD_W  = 66;
   localparam int DIST_ROOT_W = DIST_RAD_W / 2;
   localparam int AREA_RAD_W  = 138;
   localparam int AREA_ROOT_W = AREA_RAD_W / 2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 50;

   localparam logic [CSR_IDX_W-1:0] CSR_END_A_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_A_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_A_Z    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_B_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_END_B_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_END_B_Z    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DEGEN_TOL  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_TOL   = 3'd7;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic [AREA_W-1:0] triangle_area;
      logic [LEN_W-1:0]  segment_length;
      logic              on_line;
      logic              on_segment;
   } rsp_type;

endpackage

[hdl/psr_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step: takes one radicand bit pair, yields one root bit.
// ----------------------------------------------------------------------------
module psr_sqrt_cell #(
   parameter int ROOT_W = psr_pkg::DIST_ROOT_W
) (
   input  logic              clock,
   input  logic              enable,
   input  logic [1:0]        pair,
   input  logic [ROOT_W+2:0] rem_in,
   input  logic [ROOT_W-1:0] root_in,
   output logic [ROOT_W+2:0] rem_out,
   output logic [ROOT_W-1:0] root_out
);

   localparam int REM_W = ROOT_W + 3;

   logic [REM_W-1:0]  shifted;
   logic [REM_W-1:0]  trial;
   logic [REM_W-1:0]  rem_nx;
   logic [ROOT_W-1:0] root_nx;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;

   always_comb begin
      shifted = {rem_in[REM_W-3:0], pair};
      trial   = {1'b0, root_in, 2'b01};
      if (shifted >= trial) begin
         rem_nx  = shifted - trial;
         root_nx = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
         rem_nx  = shifted;
         root_nx = {root_in[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_nx;
         root_ff <= root_nx;
      end
   end

   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

[hdl/psr_isqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Chain of sqrt cells, one root bit per stage, floor(sqrt(radicand)).
// ----------------------------------------------------------------------------
module psr_isqrt #(
   parameter int RAD_W = psr_pkg::DIST_RAD_W
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [RAD_W-1:0]     radicand,
   output logic [RAD_W/2-1:0]   root
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 3;

   logic [RAD_W-1:0]  rad_ff [0:ROOT_W-2];
   logic [REM_W-1:0]  rem_w  [0:ROOT_W];
   logic [ROOT_W-1:0] root_w [0:ROOT_W];

   assign rem_w[0]  = '0;
   assign root_w[0] = '0;

   always_ff @(posedge clock) begin
      if (enable) begin
         rad_ff[0] <= radicand;
         for (int i = 1; i < ROOT_W - 1; i++) begin
            rad_ff[i] <= rad_ff[i-1];
         end
      end
   end

   for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
      logic [1:0] pair;
      if (g == 0) begin : g_first
         assign pair = radicand[RAD_W-1 -: 2];
      end else begin : g_rest
         assign pair = rad_ff[g-1][RAD_W-1-2*g -: 2];
      end
      psr_sqrt_cell #(.ROOT_W(ROOT_W)) u_cell (
         .clock    (clock),
         .enable   (enable),
         .pair     (pair),
         .rem_in   (rem_w[g]),
         .root_in  (root_w[g]),
         .rem_out  (rem_w[g+1]),
         .root_out (root_w[g+1])
      );
   end

   assign root = root_w[ROOT_W];

endmodule

[hdl/psr_delay.sv]
// ----------------------------------------------------------------------------
// Enabled delay line
// Shifts a word along a DEPTH-deep register line while enabled; cleared by reset.
// ----------------------------------------------------------------------------
module psr_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = psr_pkg::DIST_ROOT_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] line_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            line_ff[i] <= '0;
         end
      end else if (enable) begin
         line_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign q = line_ff[DEPTH-1];

endmodule

[hdl/point_segment_relation.sv]
// ----------------------------------------------------------------------------
// Point/segment relation
// Distances, Heron area and on-line / on-segment flags for a 3-D point
// against a configured segment.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | item
// req     | in  | req_valid/req_stall| req_type (point_x, point_y, point_z)
// rsp     | out | rsp_valid/rsp_stall| rsp_type (area, length, flags)
// csr     | in  | csr_valid/csr_ready| csr_index, csr_data
//
// One item per cycle while rsp is not stalled; two sqrt cell chains of 33 and
// 69 stages plus 9 arithmetic and output stages.
// The whole pipeline advances while the output register is empty or taken;
// a stalled result freezes it and stalls req.
// Synchronous reset clears valid bits and restores register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_segment_relation #(
   parameter int FRAC_BITS = psr_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  psr_pkg::req_type                    req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output psr_pkg::rsp_type                    rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [psr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [psr_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int SHIFT  = FRAC_BITS + 2;
   localparam int CW     = psr_pkg::COORD_W;
   localparam int LW     = psr_pkg::LEN_W;
   localparam int AW     = psr_pkg::AREA_W;
   localparam int DRW    = psr_pkg::DIST_RAD_W;
   localparam int DROOT  = psr_pkg::DIST_ROOT_W;
   localparam int ARW    = psr_pkg::AREA_RAD_W;
   localparam int AROOT  = psr_pkg::AREA_ROOT_W;

   function automatic logic [CW:0] abs_diff(logic signed [CW-1:0] p,
                                            logic signed [CW-1:0] q);
      logic signed [CW:0] d;
      d = (CW+1)'(p) - (CW+1)'(q);
      abs_diff = d[CW] ? (CW+1)'(-d) : (CW+1)'(d);
   endfunction

   // configuration
   logic signed [CW-1:0] end_a_ff [0:2];
   logic signed [CW-1:0] end_b_ff [0:2];
   logic [LW-1:0]        eps_ff;
   logic [AW-1:0]        tol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            end_a_ff[i] <= '0;
            end_b_ff[i] <= '0;
         end
         eps_ff <= LW'(1);
         tol_ff <= AW'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            psr_pkg::CSR_END_A_X:   end_a_ff[0] <= csr_data[CW-1:0];
            psr_pkg::CSR_END_A_Y:   end_a_ff[1] <= csr_data[CW-1:0];
            psr_pkg::CSR_END_A_Z:   end_a_ff[2] <= csr_data[CW-1:0];
            psr_pkg::CSR_END_B_X:   end_b_ff[0] <= csr_data[CW-1:0];
            psr_pkg::CSR_END_B_Y:   end_b_ff[1] <= csr_data[CW-1:0];
            psr_pkg::CSR_END_B_Z:   end_b_ff[2] <= csr_data[CW-1:0];
            psr_pkg::CSR_DEGEN_TOL: eps_ff      <= csr_data[LW-1:0];
            psr_pkg::CSR_AREA_TOL:  tol_ff      <= csr_data[AW-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic adv;
   logic rsp_valid_ff;
   psr_pkg::rsp_type rsp_item_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   logic signed [CW-1:0] pt [0:2];
   assign pt[0] = req_item.point_x;
   assign pt[1] = req_item.point_y;
   assign pt[2] = req_item.point_z;

   // stages 1..3: |differences|, squares, sums
   logic [CW:0]    abs_ff [0:8];
   logic [DRW-1:0] sq_ff  [0:8];
   logic [DRW-1:0] sum_ff [0:2];
   logic v1_ff, v2_ff, v3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            abs_ff[i]   <= abs_diff(end_a_ff[i], pt[i]);
            abs_ff[3+i] <= abs_diff(end_b_ff[i], pt[i]);
            abs_ff[6+i] <= abs_diff(end_a_ff[i], end_b_ff[i]);
         end
         for (int i = 0; i < 9; i++) begin
            sq_ff[i] <= abs_ff[i] * abs_ff[i];
         end
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= sq_ff[3*i] + sq_ff[3*i+1] + sq_ff[3*i+2];
         end
      end
   end

   // distance roots
   logic [DROOT-1:0] dist_a, dist_b, dist_c;
   logic             dist_valid;

   psr_isqrt #(.RAD_W(DRW)) u_dist_a (
      .clock(clock), .enable(adv), .radicand(sum_ff[0]), .root(dist_a));
   psr_isqrt #(.RAD_W(DRW)) u_dist_b (
      .clock(clock), .enable(adv), .radicand(sum_ff[1]), .root(dist_b));
   psr_isqrt #(.RAD_W(DRW)) u_dist_c (
      .clock(clock), .enable(adv), .radicand(sum_ff[2]), .root(dist_c));

   psr_delay #(.WIDTH(1), .DEPTH(DROOT)) u_dist_valid (
      .clock(clock), .reset(reset), .enable(adv), .d(v3_ff), .q(dist_valid));

   // stage 4: doubled Heron terms
   logic [DROOT+1:0] s_in;
   logic [DROOT+2:0] ta_in, tb_in, tc_in;
   logic [DROOT:0]   lim;
   logic             terms_ok;

   always_comb begin
      s_in  = (DROOT+2)'(dist_a) + (DROOT+2)'(dist_b) + (DROOT+2)'(dist_c);
      ta_in = (DROOT+3)'(dist_b) + (DROOT+3)'(dist_c) - (DROOT+3)'(dist_a);
      tb_in = (DROOT+3)'(dist_a) + (DROOT+3)'(dist_c) - (DROOT+3)'(dist_b);
      tc_in = (DROOT+3)'(dist_a) + (DROOT+3)'(dist_b) - (DROOT+3)'(dist_c);
      lim   = {eps_ff, 1'b0};
      terms_ok = !ta_in[DROOT+2] && !tb_in[DROOT+2] && !tc_in[DROOT+2] &&
                 (ta_in[DROOT:0] >= lim) && (tb_in[DROOT:0] >= lim) &&
                 (tc_in[DROOT:0] >= lim);
   end

   logic [DROOT+1:0] s4_ff;
   logic [DROOT:0]   ta4_ff, tb4_ff, tc4_ff;
   logic [LW-1:0]    c4_ff, c5_ff, c6_ff, c7_ff, c8_ff;
   logic             pre4_ff, pre5_ff, pre6_ff, pre7_ff, pre8_ff;
   logic             v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;

   // stages 5..8: product s*ta*tb*tc from partial products
   localparam int MW = 2 * DROOT + 3;
   localparam int LO = MW / 2 + 1;
   localparam int HI = MW - LO;

   logic [MW-1:0]      m1_ff, m2_ff;
   logic [2*LO-1:0]    ll_ff, ll7_ff;
   logic [LO+HI-1:0]   lh_ff, hl_ff;
   logic [2*HI-1:0]    hh_ff, hh7_ff;
   logic [LO+HI:0]     mid_ff;
   logic [ARW-1:0]     prod_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_ff   <= terms_ok ? s_in : '0;
         ta4_ff  <= ta_in[DROOT:0];
         tb4_ff  <= tb_in[DROOT:0];
         tc4_ff  <= tc_in[DROOT:0];
         c4_ff   <= dist_c;
         pre4_ff <= (dist_c >= dist_a) && (dist_c >= dist_b);

         m1_ff   <= MW'(s4_ff * ta4_ff);
         m2_ff   <= MW'(tb4_ff * tc4_ff);
         c5_ff   <= c4_ff;
         pre5_ff <= pre4_ff;

         ll_ff   <= m1_ff[LO-1:0] * m2_ff[LO-1:0];
         lh_ff   <= m1_ff[LO-1:0] * m2_ff[MW-1:LO];
         hl_ff   <= m1_ff[MW-1:LO] * m2_ff[LO-1:0];
         hh_ff   <= m1_ff[MW-1:LO] * m2_ff[MW-1:LO];
         c6_ff   <= c5_ff;
         pre6_ff <= pre5_ff;

         mid_ff  <= (LO+HI+1)'(lh_ff) + (LO+HI+1)'(hl_ff);
         ll7_ff  <= ll_ff;
         hh7_ff  <= hh_ff;
         c7_ff   <= c6_ff;
         pre7_ff <= pre6_ff;

         prod_ff <= (ARW'(hh7_ff) << (2*LO)) + (ARW'(mid_ff) << LO) + ARW'(ll7_ff);
         c8_ff   <= c7_ff;
         pre8_ff <= pre7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= dist_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   // area root, side data travels alongside
   logic [AROOT-1:0] area_root;
   logic             fin_valid;
   logic [LW-1:0]    fin_c;
   logic             fin_pre;

   psr_isqrt #(.RAD_W(ARW)) u_area (
      .clock(clock), .enable(adv), .radicand(prod_ff), .root(area_root));

   psr_delay #(.WIDTH(LW + 2), .DEPTH(AROOT)) u_side (
      .clock(clock), .reset(reset), .enable(adv),
      .d({v8_ff, c8_ff, pre8_ff}), .q({fin_valid, fin_c, fin_pre}));

   // output stage
   logic [AROOT-1:0] area_sh;
   logic [AW-1:0]    area_in;
   logic             on_line_in;

   always_comb begin
      area_sh    = area_root >> SHIFT;
      area_in    = (|area_sh[AROOT-1:AW]) ? '1 : area_sh[AW-1:0];
      on_line_in = area_in <= tol_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= fin_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && fin_valid) begin
         rsp_item_ff.triangle_area  <= area_in;
         rsp_item_ff.segment_length <= fin_c;
         rsp_item_ff.on_line        <= on_line_in;
         rsp_item_ff.on_segment     <= on_line_in && fin_pre;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `PSR_ASSERT_NEVER(a_stall_back, rsp_valid_ff && rsp_stall && !req_stall, "stall not propagated")
   `PSR_ASSERT_NEVER(a_seg_line, rsp_valid_ff && rsp_item_ff.on_segment && !rsp_item_ff.on_line, "on_segment without on_line")
   `PSR_ASSERT_NEVER(a_off_line, rsp_valid_ff && !rsp_item_ff.on_line && rsp_item_ff.triangle_area == '0, "zero area off line")

endmodule
